// ----- design/barycentric_point_in_triangle_defines.svh -----
// Assertion macros shared by the barycentric point-in-triangle design.
// Every property is sampled on the rising edge of clk and is disabled while rst is high.
`ifndef BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH
`define BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH

// The antecedent holds in a cycle, so the consequent must hold in that same cycle.
`define BPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holds in a cycle, so the consequent must hold in the next cycle.
`define BPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bpt_pkg.sv -----
`timescale 1ns / 1ps
package bpt_pkg;

  localparam int QB = 41;                          // quotient bits before clamping
  localparam logic [QB-1:0] QUOT_LIMIT = 41'h100_0000_0000;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [33:0] prod_t;
  typedef logic signed [35:0] dot_t;
  typedef logic signed [71:0] wprod_t;
  typedef logic signed [72:0] num_t;
  typedef logic [72:0] mag_t;
  typedef logic [73:0] rem_t;
  typedef logic [QB-1:0] quot_t;
  typedef logic signed [41:0] wt_t;
  typedef logic signed [43:0] wsum_t;
  typedef logic signed [23:0] weight_t;

  typedef struct packed {
    logic signed [35:0] hh;
    logic signed [36:0] hl;
    logic signed [36:0] lh;
    logic [35:0] ll;
  } pp_t;

  typedef struct packed {
    rem_t rem;
    quot_t sh;   // remaining dividend bits on the left, quotient bits shift in on the right
    logic neg;
    logic big;
  } div_lane_t;

  typedef struct packed {
    mag_t den;
    logic degen;
    logic in_tri;
    div_lane_t u;
    div_lane_t v;
  } div_stage_t;

  // A 36 by 36 signed product split into four partial products of about 18 bits a side.
  function automatic pp_t mul_parts(dot_t a, dot_t b);
    pp_t r;
    r.hh = $signed(a[35:18]) * $signed(b[35:18]);
    r.hl = $signed(a[35:18]) * $signed({1'b0, b[17:0]});
    r.lh = $signed({1'b0, a[17:0]}) * $signed(b[35:18]);
    r.ll = a[17:0] * b[17:0];
    return r;
  endfunction

  function automatic wprod_t mul_sum(pp_t p);
    wprod_t hh, hl, lh, ll;
    hh = {p.hh, 36'd0};
    hl = wprod_t'(p.hl) <<< 18;
    lh = wprod_t'(p.lh) <<< 18;
    ll = {36'd0, p.ll};
    return hh + hl + lh + ll;
  endfunction

  // One restoring division step.
  function automatic div_lane_t div_step(div_lane_t l, mag_t den);
    div_lane_t r;
    rem_t t;
    logic take;
    r = l;
    t = {l.rem[72:0], l.sh[QB-1]};
    take = (t >= {1'b0, den});
    r.rem = take ? t - {1'b0, den} : t;
    r.sh = {l.sh[QB-2:0], take};
    return r;
  endfunction

  function automatic wt_t lane_weight(div_lane_t l);
    quot_t q;
    wt_t m;
    q = (l.big || l.sh > QUOT_LIMIT) ? QUOT_LIMIT : l.sh;
    m = $signed({1'b0, q});
    return l.neg ? -m : m;
  endfunction

  function automatic weight_t sat24(wsum_t x);
    weight_t r;
    if (x > wsum_t'(8388607)) begin
      r = 24'sh7FFFFF;
    end else if (x < -wsum_t'(8388608)) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

// ----- design/barycentric_point_in_triangle.sv -----
`timescale 1ns / 1ps
// Barycentric point-in-triangle test. An item enters whenever start is high. busy is always
// low, so one item can be accepted in every clock cycle. done is high for one cycle while the
// result is on the ports. The receiver cannot stall the block. The pipeline has:
//  - 7 stages for the differences, the dot products and the split 36-bit products;
//  - 1 setup stage;
//  - 41 restoring-division stages, one quotient bit per stage, that work the u and v lanes
//    side by side;
//  - an output register.
// Write edge_tolerance only while no item is in flight.
module barycentric_point_in_triangle #(
  parameter int COORD_FRAC_BITS = 12,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  bpt_pkg::coord_t a_x,
  input  bpt_pkg::coord_t a_y,
  input  bpt_pkg::coord_t a_z,
  input  bpt_pkg::coord_t b_x,
  input  bpt_pkg::coord_t b_y,
  input  bpt_pkg::coord_t b_z,
  input  bpt_pkg::coord_t c_x,
  input  bpt_pkg::coord_t c_y,
  input  bpt_pkg::coord_t c_z,
  input  bpt_pkg::coord_t p_x,
  input  bpt_pkg::coord_t p_y,
  input  bpt_pkg::coord_t p_z,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [11:0] cfg_data,
  output logic done,
  output logic inside_res,
  output logic degenerate,
  output bpt_pkg::weight_t weight_u,
  output bpt_pkg::weight_t weight_v,
  output bpt_pkg::weight_t weight_w
);
  import bpt_pkg::*;

  localparam int SW = 74;
  localparam int XW = SW + COORD_FRAC_BITS + 13;
  localparam int NNW = 73 + WEIGHT_FRAC_BITS;
  localparam int LATENCY = 9 + QB;

  logic [11:0] edge_tolerance;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_tolerance <= 12'd20;
    end else if (cfg_valid && cfg_ready) begin
      edge_tolerance <= cfg_data;
    end
  end

  // Valid bits for stages 1 to 7.
  logic [7:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], start && !busy};
    end
  end

  // Stage 1: edge vectors. e[0] = C-A, e[1] = B-A, e[2] = P-A.
  diff_t e_s1 [3][3];

  always_ff @(posedge clk) begin
    e_s1[0][0] <= diff_t'(c_x) - diff_t'(a_x);
    e_s1[0][1] <= diff_t'(c_y) - diff_t'(a_y);
    e_s1[0][2] <= diff_t'(c_z) - diff_t'(a_z);
    e_s1[1][0] <= diff_t'(b_x) - diff_t'(a_x);
    e_s1[1][1] <= diff_t'(b_y) - diff_t'(a_y);
    e_s1[1][2] <= diff_t'(b_z) - diff_t'(a_z);
    e_s1[2][0] <= diff_t'(p_x) - diff_t'(a_x);
    e_s1[2][1] <= diff_t'(p_y) - diff_t'(a_y);
    e_s1[2][2] <= diff_t'(p_z) - diff_t'(a_z);
  end

  // Stage 2: component products. Dots in order d00, d01, d02, d11, d12.
  prod_t p_s2 [5][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_s2[0][k] <= e_s1[0][k] * e_s1[0][k];
      p_s2[1][k] <= e_s1[0][k] * e_s1[1][k];
      p_s2[2][k] <= e_s1[0][k] * e_s1[2][k];
      p_s2[3][k] <= e_s1[1][k] * e_s1[1][k];
      p_s2[4][k] <= e_s1[1][k] * e_s1[2][k];
    end
  end

  // Stage 3: dot products.
  dot_t d_s3 [5];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 5; j++) begin
      d_s3[j] <= dot_t'(p_s2[j][0]) + dot_t'(p_s2[j][1]) + dot_t'(p_s2[j][2]);
    end
  end

  // Stage 4: partial products of d00*d11, d01*d01, d11*d02, d01*d12, d00*d12 and d01*d02.
  pp_t pp_s4 [6];

  always_ff @(posedge clk) begin
    pp_s4[0] <= mul_parts(d_s3[0], d_s3[3]);
    pp_s4[1] <= mul_parts(d_s3[1], d_s3[1]);
    pp_s4[2] <= mul_parts(d_s3[3], d_s3[2]);
    pp_s4[3] <= mul_parts(d_s3[1], d_s3[4]);
    pp_s4[4] <= mul_parts(d_s3[0], d_s3[4]);
    pp_s4[5] <= mul_parts(d_s3[1], d_s3[2]);
  end

  // Stage 5: full products.
  wprod_t wp_s5 [6];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      wp_s5[j] <= mul_sum(pp_s4[j]);
    end
  end

  // Stage 6: denominator and the two numerators.
  num_t den_s6, nu_s6, nv_s6;

  always_ff @(posedge clk) begin
    den_s6 <= num_t'(wp_s5[0]) - num_t'(wp_s5[1]);
    nu_s6  <= num_t'(wp_s5[2]) - num_t'(wp_s5[3]);
    nv_s6  <= num_t'(wp_s5[4]) - num_t'(wp_s5[5]);
  end

  // Stage 7: magnitudes, the bound difference and the tolerance partial products.
  // The denominator is never negative, so its bits serve as its magnitude.
  mag_t den_s7, mu_s7, mv_s7;
  logic degen_s7, nneg_s7, negu_s7, negv_s7;
  logic signed [SW-1:0] s_s7;
  logic [36:0] tp_s7 [3];

  always_ff @(posedge clk) begin
    den_s7 <= den_s6;
    degen_s7 <= (den_s6 == '0);
    negu_s7 <= nu_s6[72];
    negv_s7 <= nv_s6[72];
    nneg_s7 <= !nu_s6[72] && !nv_s6[72];
    mu_s7 <= nu_s6[72] ? mag_t'(-nu_s6) : mag_t'(nu_s6);
    mv_s7 <= nv_s6[72] ? mag_t'(-nv_s6) : mag_t'(nv_s6);
    s_s7 <= SW'(nu_s6) + SW'(nv_s6) - SW'(den_s6);
    tp_s7[0] <= 37'(den_s6[23:0] * edge_tolerance);
    tp_s7[1] <= 37'(den_s6[47:24] * edge_tolerance);
    tp_s7[2] <= 37'(den_s6[72:48] * edge_tolerance);
  end

  // Stage 8: the inside decision and the setup of the dividers.
  // Inside means den != 0, nu >= 0, nv >= 0 and (nu+nv-den) * 2^COORD_FRAC_BITS < den * edge_tolerance.
  logic [XW-1:0] dt;
  logic signed [XW-1:0] sx;
  logic [NNW-1:0] nn_u, nn_v;
  div_stage_t div_init;

  always_comb begin
    dt = XW'(tp_s7[0]) + (XW'(tp_s7[1]) << 24) + (XW'(tp_s7[2]) << 48);
    sx = XW'(s_s7) <<< COORD_FRAC_BITS;
    nn_u = NNW'(mu_s7) << WEIGHT_FRAC_BITS;
    nn_v = NNW'(mv_s7) << WEIGHT_FRAC_BITS;
    div_init.den = den_s7;
    div_init.degen = degen_s7;
    div_init.in_tri = !degen_s7 && nneg_s7 && (sx < $signed(dt));
    // A quotient of 2^QB or more shows before any step and is clamped later.
    div_init.u.big = ((nn_u >> QB) >= NNW'(den_s7));
    div_init.v.big = ((nn_v >> QB) >= NNW'(den_s7));
    div_init.u.rem = div_init.u.big ? '0 : rem_t'(nn_u >> QB);
    div_init.v.rem = div_init.v.big ? '0 : rem_t'(nn_v >> QB);
    div_init.u.sh = nn_u[QB-1:0];
    div_init.v.sh = nn_v[QB-1:0];
    div_init.u.neg = negu_s7;
    div_init.v.neg = negv_s7;
  end

  div_stage_t dpipe [QB+1];
  logic [QB:0] dvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else begin
      dvld <= {dvld[QB-1:0], vld[7]};
    end
  end

  always_ff @(posedge clk) begin
    dpipe[0] <= div_init;
  end

  genvar g;
  generate
    for (g = 1; g <= QB; g++) begin : g_div
      always_ff @(posedge clk) begin
        dpipe[g].den <= dpipe[g-1].den;
        dpipe[g].degen <= dpipe[g-1].degen;
        dpipe[g].in_tri <= dpipe[g-1].in_tri;
        dpipe[g].u <= div_step(dpipe[g-1].u, dpipe[g-1].den);
        dpipe[g].v <= div_step(dpipe[g-1].v, dpipe[g-1].den);
      end
    end
  endgenerate

  // Output stage. w is formed from the clamped but unsaturated u and v.
  wt_t wu, wv;
  wsum_t ww;

  always_comb begin
    wu = lane_weight(dpipe[QB].u);
    wv = lane_weight(dpipe[QB].v);
    ww = (wsum_t'(1) <<< WEIGHT_FRAC_BITS) - wsum_t'(wu) - wsum_t'(wv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvld[QB];
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= dpipe[QB].degen;
    inside_res <= dpipe[QB].in_tri;
    weight_u <= dpipe[QB].degen ? '0 : sat24(wsum_t'(wu));
    weight_v <= dpipe[QB].degen ? '0 : sat24(wsum_t'(wv));
    weight_w <= dpipe[QB].degen ? '0 : sat24(ww);
  end

  `include "barycentric_point_in_triangle_defines.svh"

  `BPT_ASSERT_IMP(a_degen_zero, done && degenerate, !inside_res && weight_u == 0 && weight_v == 0 && weight_w == 0, "degenerate result with nonzero fields")
  `BPT_ASSERT_IMP(a_inside_nonneg, done && inside_res, !degenerate && !weight_u[23] && !weight_v[23], "inside result with a negative weight")
  `BPT_ASSERT_IMP(a_done_source, done, $past(start && !busy, LATENCY), "result without an item accepted at the pipeline latency")
  `BPT_ASSERT_NXT(a_last_stage_done, dvld[QB], done, "final division stage not followed by a result")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bpt_pkg::*;

  typedef coord_t item_t [12];

  typedef struct packed {
    logic in_tri;
    logic degen;
    weight_t u;
    weight_t v;
    weight_t w;
  } bary_t;

  typedef struct {
    item_t it;
    bit typed;
    bary_t r;
  } row_t;

  localparam int LATENCY = 50;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t pin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [11:0] cfg_data = '0;
  logic done, inside_res, degenerate;
  weight_t weight_u, weight_v, weight_w;

  logic [11:0] tol_shadow = 12'd20;
  bary_t bary_q[$];
  row_t dir_rows[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int inside_seen = 0;
  int degen_seen = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  initial begin
    for (int k = 0; k < 12; k++) pin[k] = '0;
  end

  barycentric_point_in_triangle u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(pin[0]), .a_y(pin[1]), .a_z(pin[2]),
    .b_x(pin[3]), .b_y(pin[4]), .b_z(pin[5]),
    .c_x(pin[6]), .c_y(pin[7]), .c_z(pin[8]),
    .p_x(pin[9]), .p_y(pin[10]), .p_z(pin[11]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .inside_res(inside_res), .degenerate(degenerate),
    .weight_u(weight_u), .weight_v(weight_v), .weight_w(weight_w)
  );

  // Truncated quotient n/d scaled by the weight fraction, clamped at 2^40 in magnitude.
  function automatic logic signed [63:0] scaled_quot(logic signed [127:0] n,
                                                     logic signed [127:0] d);
    logic [127:0] mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag << 16) / d;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (n < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic weight_t clamp24(logic signed [63:0] x);
    if (x > 64'sd8388607) return 24'sh7FFFFF;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic bary_t bary_weights(item_t it, logic [11:0] tol);
    logic signed [127:0] e0 [3], e1 [3], e2 [3];
    logic signed [127:0] d00, d01, d02, d11, d12, den, nu, nv;
    logic [127:0] lhs, rhs;
    logic signed [63:0] u, v;
    bary_t r;
    for (int k = 0; k < 3; k++) begin
      e1[k] = $signed(it[3 + k]) - $signed(it[k]);
      e0[k] = $signed(it[6 + k]) - $signed(it[k]);
      e2[k] = $signed(it[9 + k]) - $signed(it[k]);
    end
    d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
    d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
    d02 = e0[0] * e2[0] + e0[1] * e2[1] + e0[2] * e2[2];
    d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    d12 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    den = d00 * d11 - d01 * d01;
    nu = d11 * d02 - d01 * d12;
    nv = d00 * d12 - d01 * d02;
    r = '0;
    if (den <= 0) begin
      r.degen = 1'b1;
      return r;
    end
    u = scaled_quot(nu, den);
    v = scaled_quot(nv, den);
    r.u = clamp24(u);
    r.v = clamp24(v);
    r.w = clamp24(64'sd65536 - u - v);
    if (nu >= 0 && nv >= 0) begin
      lhs = (nu + nv) * 128'd4096;
      rhs = den * (128'd4096 + tol);
      r.in_tri = lhs < rhs;
    end
    return r;
  endfunction

  // Coordinates inside a box of half-width span, kept in range.
  function automatic coord_t near_coord(int base, int span);
    int x;
    x = base + $urandom_range(0, 2 * span) - span;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[15:0];
  endfunction

  // Well-formed triangles with P placed by chosen weights; some collinear or noise.
  function automatic item_t random_item();
    item_t it;
    int span, kind, cu, cv, px;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 16000 : $urandom_range(16, 4000);
    if (kind == 0) begin
      for (int k = 0; k < 12; k++) it[k] = coord_t'($urandom);
      return it;
    end
    for (int k = 0; k < 3; k++) begin
      it[k] = near_coord(0, 16000);
      it[3 + k] = near_coord(it[k], span);
      it[6 + k] = near_coord(it[k], span);
    end
    if (kind == 1) begin
      // Collinear vertices: C on the line through A and B.
      for (int k = 0; k < 3; k++) it[6 + k] = near_coord(2 * it[3 + k] - it[k], 0);
      if ($urandom_range(0, 1) == 0) for (int k = 0; k < 3; k++) it[3 + k] = it[k];
    end
    cu = $urandom_range(0, 1300) - 100;
    cv = $urandom_range(0, 1300) - 100;
    for (int k = 0; k < 3; k++) begin
      px = it[k] + (cu * (it[6 + k] - it[k]) + cv * (it[3 + k] - it[k])) / 1000;
      if (kind == 2) px += $urandom_range(0, 8) - 4;
      it[9 + k] = near_coord(px, 0);
    end
    return it;
  endfunction

  function automatic item_t make_item(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz, int px, int py, int pz);
    item_t it;
    it[0] = coord_t'(ax); it[1] = coord_t'(ay); it[2] = coord_t'(az);
    it[3] = coord_t'(bx); it[4] = coord_t'(by); it[5] = coord_t'(bz);
    it[6] = coord_t'(cx); it[7] = coord_t'(cy); it[8] = coord_t'(cz);
    it[9] = coord_t'(px); it[10] = coord_t'(py); it[11] = coord_t'(pz);
    return it;
  endfunction

  task automatic add_row(item_t it, bit typed, bary_t r);
    row_t row;
    row.it = it;
    row.typed = typed;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(item_t it, bit typed, bary_t r);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    pin = it;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    bary_q.push_back(typed ? r : bary_weights(it, tol_shadow));
    beats_in++;
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [11:0] val);
    start = 1'b0;
    while (bary_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_shadow = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result checking and the watchdog share the rising edge.
  always @(posedge clk) begin
    bary_t exp_r;
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (done) begin
        beats_out++;
        if (inside_res) inside_seen++;
        if (degenerate) degen_seen++;
        if (bary_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          exp_r = bary_q.pop_front();
          if (exp_r.in_tri !== inside_res) begin
            $display("%0t: inside_res expected %0d actual %0d", $time, exp_r.in_tri,
                     inside_res);
            errors++;
          end
          if (exp_r.degen !== degenerate) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, exp_r.degen,
                     degenerate);
            errors++;
          end
          if (exp_r.u !== weight_u) begin
            $display("%0t: weight_u expected %0d actual %0d", $time, exp_r.u, weight_u);
            errors++;
          end
          if (exp_r.v !== weight_v) begin
            $display("%0t: weight_v expected %0d actual %0d", $time, exp_r.v, weight_v);
            errors++;
          end
          if (exp_r.w !== weight_w) begin
            $display("%0t: weight_w expected %0d actual %0d", $time, exp_r.w, weight_w);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    bary_t typed_r, none_r;
    logic [11:0] tol_plan [6];
    none_r = '0;
    typed_r = '0;
    tol_plan[0] = 12'd0;
    tol_plan[1] = 12'd4095;
    tol_plan[2] = 12'($urandom_range(1, 4094));
    tol_plan[3] = 12'd1;
    tol_plan[4] = 12'($urandom_range(0, 4095));
    tol_plan[5] = 12'd20;

    // Degenerate triangles: the vertices coincide or are collinear, so the triangle collapses.
    typed_r.degen = 1'b1;
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, typed_r);
    add_row(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                      -32768, -32768, -32768), 1'b1, typed_r);
    add_row(make_item(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767,
                      5, -7, 9), 1'b1, typed_r);
    // Unit right triangle: P at A, at C and at B, then at further points near and off the triangle.
    typed_r = '0;
    typed_r.in_tri = 1'b1;
    typed_r.w = 24'sd65536;
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0), 1'b1, typed_r);
    typed_r.w = '0;
    typed_r.u = 24'sd65536;
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 4096, 0), 1'b1, typed_r);
    typed_r.u = '0;
    typed_r.v = 24'sd65536;
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 4096, 0, 0), 1'b1, typed_r);
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 2048, 2048, 0), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 2050, 2050, 0), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, -1, 100, 0), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 100, -1, 4000), 1'b0, none_r);
    // Extreme spans and tiny triangles drive the weights into saturation.
    add_row(make_item(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767,
                      -32768, 32767, 32767, 32767), 1'b0, none_r);
    add_row(make_item(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767,
                      -32768, -32768, -32768), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0), 1'b0, none_r);
    add_row(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 32767, 0), 1'b0, none_r);
    add_row(make_item(-21846, 21845, -21846, 21845, -21846, 21845, -1, 1, -1,
                      -32768, 32767, -32768), 1'b0, none_r);
    add_row(make_item(100, 200, 300, 4196, 200, 300, 100, 4296, 300, 1100, 1200, 1300),
            1'b0, none_r);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].r);
    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(tol_plan[ph]);
      if (ph == 5) no_idle = 1'b1;
      for (int n = 0; n < 225; n++) send_beat(random_item(), 1'b0, none_r);
    end
    start = 1'b0;

    while (bary_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Run covered %0d items and %0d result beats over six tolerance settings,",
             beats_in, beats_out);
    $display("with %0d inside and %0d degenerate results.", inside_seen, degen_seen);
    if (errors == 0 && bary_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/bpt_pkg.sv
design/barycentric_point_in_triangle.sv
sim/tb_top.sv
